// ===== hdl/seeded_nxn_cluster_finder_unit_defines.svh =====
// Assertion macros for the seeded NxN cluster finder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SEEDED_NXN_CLUSTER_FINDER_UNIT_DEFINES_SVH
`define SEEDED_NXN_CLUSTER_FINDER_UNIT_DEFINES_SVH

// same-cycle implication
`define SNXN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SNXN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/snxn_pkg.sv =====
// Shared types and constants for the seeded NxN cluster finder.
// No dependencies.
package snxn_pkg;

  localparam int MAX_CELLS_DEF = 64;
  localparam int SM_COLS_DEF   = 48;
  localparam int CSUM_W        = 8;
  localparam int ADDR_W        = 5;

  typedef enum logic [2:0] {
    REG_MIN_CUT   = 3'd0,
    REG_SEED_THR  = 3'd1,
    REG_TIME_MIN  = 3'd2,
    REG_TIME_MAX  = 3'd3,
    REG_TIME_CUT  = 3'd4,
    REG_ROW_WIN   = 3'd5,
    REG_COL_WIN   = 3'd6,
    REG_GRADIENT  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_EV,
    ST_SEED_PUT,
    ST_MEM_RD,
    ST_MEM_EV,
    ST_CL_END,
    ST_EV_END
  } state_t;

  typedef struct packed {
    logic [15:0]        min_cut;
    logic [15:0]        seed_thr;
    logic signed [15:0] time_min;
    logic signed [15:0] time_max;
    logic [15:0]        time_cut;
    logic [4:0]         row_win;
    logic [6:0]         col_win;
    logic               gradient;
  } cfg_t;

  typedef struct packed {
    logic [14:0]        cell_id;
    logic [4:0]         sm;
    logic [4:0]         row;
    logic [5:0]         col;
    logic [15:0]        energy;
    logic signed [15:0] hit_time;
  } entry_t;

  typedef struct packed {
    logic seed_ok;
    logic member_ok;
  } eval_t;

endpackage

// ===== hdl/snxn_ifs.sv =====
// Handshake channel interfaces for cell input and cluster results.
// No dependencies.
interface snxn_in_if;
  logic               valid;
  logic               ready;
  logic [14:0]        cell_id;
  logic [4:0]         supermodule;
  logic [4:0]         row;
  logic [5:0]         col;
  logic [15:0]        energy;
  logic signed [15:0] hit_time;
  logic               last_cell;
  modport source (output valid, cell_id, supermodule, row, col, energy, hit_time, last_cell,
                  input ready);
  modport sink (input valid, cell_id, supermodule, row, col, energy, hit_time, last_cell,
                output ready);
endinterface

interface snxn_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] out_cell_id;
  logic [5:0]  cluster_index;
  logic [15:0] cell_energy;
  logic        is_seed;
  logic        end_of_cluster;
  logic        end_of_event;
  logic        empty_event;
  logic        overflow;
  modport source (output valid, out_cell_id, cluster_index, cell_energy, is_seed,
                  end_of_cluster, end_of_event, empty_event, overflow, input ready);
  modport sink (input valid, out_cell_id, cluster_index, cell_energy, is_seed,
                end_of_cluster, end_of_event, empty_event, overflow, output ready);
endinterface

// ===== hdl/snxn_eval.sv =====
// Shared compare unit: seed qualification and cluster membership of one cell.
// Depends on snxn_pkg.
module snxn_eval #(
  parameter int SM_COLS = snxn_pkg::SM_COLS_DEF
) (
  input  snxn_pkg::cfg_t   cfg,
  input  snxn_pkg::entry_t cand,
  input  snxn_pkg::entry_t seed,
  input  logic             found,
  output snxn_pkg::eval_t  res
);

  logic signed [16:0]          dt;
  logic [16:0]                 adt;
  logic [4:0]                  dr;
  logic [snxn_pkg::CSUM_W-1:0] cs, cm, dc;
  logic                        same, pair, t_ok, geo_ok, grad_ok;

  always_comb begin
    dt   = {seed.hit_time[15], seed.hit_time} - {cand.hit_time[15], cand.hit_time};
    adt  = dt[16] ? 17'(-dt) : 17'(dt);
    t_ok = adt <= {1'b0, cfg.time_cut};
    dr   = (seed.row >= cand.row) ? seed.row - cand.row : cand.row - seed.row;
    same = seed.sm == cand.sm;
    pair = seed.sm[4:1] == cand.sm[4:1];
    cs   = snxn_pkg::CSUM_W'(seed.col);
    cm   = snxn_pkg::CSUM_W'(cand.col);
    if (!same) begin
      if (seed.sm[0]) begin
        cs = cs + snxn_pkg::CSUM_W'(SM_COLS);
      end else begin
        cm = cm + snxn_pkg::CSUM_W'(SM_COLS);
      end
    end
    dc      = (cs >= cm) ? cs - cm : cm - cs;
    geo_ok  = pair && (dc <= snxn_pkg::CSUM_W'(cfg.col_win)) && (dr <= cfg.row_win);
    grad_ok = !cfg.gradient || (cand.energy <= seed.energy);
    res.member_ok = t_ok && geo_ok && grad_ok;
    res.seed_ok   = (cand.energy > cfg.seed_thr) && (cand.hit_time < cfg.time_max) &&
                    (cand.hit_time > cfg.time_min) && (!found || cand.energy > seed.energy);
  end

endmodule

// ===== hdl/seeded_nxn_cluster_finder_unit.sv =====
// Seeded NxN cluster finder, top level.
// Depends on snxn_pkg, snxn_ifs, snxn_eval and the assertion macro header.
//
// Usage: cells of one event enter on in_ch, one item per cycle, the last one
// flagged by last_cell. Cells at or below min_cut are dropped; cells
// beyond MAX_CELLS are dropped and reported by overflow on every result.
// After the last cell in_ch.ready falls while the stored cells are clustered:
// each seed search and each member search walks the stored cells through one
// memory read port and one shared compare unit, a read state and then an
// evaluate state per stored cell. in_ch.ready returns at the end of the event.
// Results leave on out_ch from an output register: seed first, then members
// in load order, end_of_cluster on the last cell of each cluster and
// end_of_event on the final item; an event with no cluster gives one item
// with empty_event set. When out_ch stalls the search holds until the output
// register frees. Configuration is written over the APB port (cfg_) while
// the block is idle; the user must keep to this, as the block does not
// enforce it. Reset (rst_n, synchronous) restores the register defaults and
// empties the event; the cell memory needs no clear.
`include "seeded_nxn_cluster_finder_unit_defines.svh"
module seeded_nxn_cluster_finder_unit #(
  parameter int MAX_CELLS = snxn_pkg::MAX_CELLS_DEF,
  parameter int SM_COLS   = snxn_pkg::SM_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  snxn_in_if.sink                     in_ch,
  snxn_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [snxn_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int IW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);

  snxn_pkg::state_t  state_r, state_nxt;
  snxn_pkg::cfg_t    cfg_r;
  snxn_pkg::entry_t  mem [MAX_CELLS];
  snxn_pkg::entry_t  rd_q, seed_r, wr_entry;
  snxn_pkg::eval_t   ev;
  snxn_pkg::reg_idx_t reg_idx;

  logic [MAX_CELLS-1:0] present_r;
  logic [CW-1:0]        cnt_r, idx_r;
  logic [IW-1:0]        idx, seed_idx_r;
  logic [5:0]           cluster_r;
  logic                 dropped_r, found_r;

  logic        pend_v_r, pend_seed_r, pend_eoc_r;
  logic [14:0] pend_id_r;
  logic [5:0]  pend_cidx_r;
  logic [15:0] pend_energy_r;

  logic        out_v_r, o_seed_r, o_eoc_r, o_eoe_r, o_empty_r, o_ovf_r;
  logic [14:0] o_id_r;
  logic [5:0]  o_cidx_r;
  logic [15:0] o_energy_r;

  logic take_in, keep, at_end, out_free, hit, seed_hit, rd_en, in_member;
  logic seed_take, put_seed, put_mem, step, cl_end, ev_done, push_out, cfg_wr;

  assign idx      = idx_r[IW-1:0];
  assign at_end   = idx_r == cnt_r;
  assign out_free = !out_v_r || out_ch.ready;
  assign take_in  = in_ch.valid && in_ch.ready;
  assign keep     = in_ch.energy > cfg_r.min_cut;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx  = snxn_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign in_member = (state_r == snxn_pkg::ST_MEM_RD) || (state_r == snxn_pkg::ST_MEM_EV) ||
                     (state_r == snxn_pkg::ST_CL_END);

  assign wr_entry = '{cell_id: in_ch.cell_id, sm: in_ch.supermodule, row: in_ch.row,
                      col: in_ch.col, energy: in_ch.energy, hit_time: in_ch.hit_time};

  snxn_eval #(.SM_COLS(SM_COLS)) u_eval (
    .cfg   (cfg_r),
    .cand  (rd_q),
    .seed  (seed_r),
    .found (found_r),
    .res   (ev)
  );

  assign hit      = present_r[idx] && (idx != seed_idx_r) && ev.member_ok;
  assign seed_hit = present_r[idx] && ev.seed_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      snxn_pkg::ST_IDLE:     if (take_in && in_ch.last_cell) state_nxt = snxn_pkg::ST_SEED_RD;
      snxn_pkg::ST_SEED_RD: begin
        if (!at_end) state_nxt = snxn_pkg::ST_SEED_EV;
        else if (found_r) state_nxt = snxn_pkg::ST_SEED_PUT;
        else state_nxt = snxn_pkg::ST_EV_END;
      end
      snxn_pkg::ST_SEED_EV:  state_nxt = snxn_pkg::ST_SEED_RD;
      snxn_pkg::ST_SEED_PUT: if (!pend_v_r || out_free) state_nxt = snxn_pkg::ST_MEM_RD;
      snxn_pkg::ST_MEM_RD:   state_nxt = at_end ? snxn_pkg::ST_CL_END : snxn_pkg::ST_MEM_EV;
      snxn_pkg::ST_MEM_EV:   if (!(hit && pend_v_r && !out_free)) state_nxt = snxn_pkg::ST_MEM_RD;
      snxn_pkg::ST_CL_END:   state_nxt = snxn_pkg::ST_SEED_RD;
      snxn_pkg::ST_EV_END:   if (out_free) state_nxt = snxn_pkg::ST_IDLE;
      default:               state_nxt = snxn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state_r == snxn_pkg::ST_IDLE;
    rd_en     = (state_r == snxn_pkg::ST_SEED_RD || state_r == snxn_pkg::ST_MEM_RD) && !at_end;
    seed_take = (state_r == snxn_pkg::ST_SEED_EV) && seed_hit;
    put_seed  = (state_r == snxn_pkg::ST_SEED_PUT) && (!pend_v_r || out_free);
    put_mem   = (state_r == snxn_pkg::ST_MEM_EV) && hit && (!pend_v_r || out_free);
    step      = (state_r == snxn_pkg::ST_SEED_EV) ||
                ((state_r == snxn_pkg::ST_MEM_EV) && (!hit || put_mem));
    cl_end    = state_r == snxn_pkg::ST_CL_END;
    ev_done   = (state_r == snxn_pkg::ST_EV_END) && out_free;
    push_out  = ((put_seed || put_mem) && pend_v_r) || ev_done;
  end

  always_ff @(posedge clk) begin
    if (take_in && keep && (cnt_r < CW'(MAX_CELLS))) begin
      mem[cnt_r[IW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= snxn_pkg::ST_IDLE;
      present_r <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      cluster_r <= '0;
      dropped_r <= 1'b0;
      found_r   <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      cfg_r     <= '{min_cut: 16'd0, seed_thr: 16'd0, time_min: -16'sd32768,
                     time_max: 16'sd32767, time_cut: 16'hFFFF, row_win: 5'd1,
                     col_win: 7'd1, gradient: 1'b0};
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (reg_idx)
          snxn_pkg::REG_MIN_CUT:  cfg_r.min_cut  <= cfg_pwdata[15:0];
          snxn_pkg::REG_SEED_THR: cfg_r.seed_thr <= cfg_pwdata[15:0];
          snxn_pkg::REG_TIME_MIN: cfg_r.time_min <= cfg_pwdata[15:0];
          snxn_pkg::REG_TIME_MAX: cfg_r.time_max <= cfg_pwdata[15:0];
          snxn_pkg::REG_TIME_CUT: cfg_r.time_cut <= cfg_pwdata[15:0];
          snxn_pkg::REG_ROW_WIN:  cfg_r.row_win  <= cfg_pwdata[4:0];
          snxn_pkg::REG_COL_WIN:  cfg_r.col_win  <= cfg_pwdata[6:0];
          snxn_pkg::REG_GRADIENT: cfg_r.gradient <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (take_in && keep) begin
        if (cnt_r < CW'(MAX_CELLS)) begin
          present_r[cnt_r[IW-1:0]] <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (take_in && in_ch.last_cell) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (seed_take) begin
        found_r    <= 1'b1;
        seed_r     <= rd_q;
        seed_idx_r <= idx;
      end
      if (step) idx_r <= idx_r + 1'b1;
      if (put_seed) begin
        idx_r         <= '0;
        pend_v_r      <= 1'b1;
        pend_id_r     <= seed_r.cell_id;
        pend_energy_r <= seed_r.energy;
        pend_cidx_r   <= cluster_r;
        pend_seed_r   <= 1'b1;
        pend_eoc_r    <= 1'b0;
      end
      if (put_mem) begin
        present_r[idx] <= 1'b0;
        pend_v_r       <= 1'b1;
        pend_id_r      <= rd_q.cell_id;
        pend_energy_r  <= rd_q.energy;
        pend_cidx_r    <= cluster_r;
        pend_seed_r    <= 1'b0;
        pend_eoc_r     <= 1'b0;
      end
      if (cl_end) begin
        pend_eoc_r            <= 1'b1;
        present_r[seed_idx_r] <= 1'b0;
        cluster_r             <= cluster_r + 1'b1;
        found_r               <= 1'b0;
        idx_r                 <= '0;
      end
      if (push_out) begin
        out_v_r    <= 1'b1;
        o_eoe_r    <= ev_done;
        o_ovf_r    <= dropped_r;
        o_empty_r  <= ev_done && !pend_v_r;
        o_id_r     <= pend_v_r ? pend_id_r : '0;
        o_cidx_r   <= pend_v_r ? pend_cidx_r : '0;
        o_energy_r <= pend_v_r ? pend_energy_r : '0;
        o_seed_r   <= pend_v_r && pend_seed_r;
        o_eoc_r    <= pend_v_r && pend_eoc_r;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (ev_done) begin
        present_r <= '0;
        cnt_r     <= '0;
        cluster_r <= '0;
        dropped_r <= 1'b0;
        pend_v_r  <= 1'b0;
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      snxn_pkg::REG_MIN_CUT:  cfg_prdata = 32'(cfg_r.min_cut);
      snxn_pkg::REG_SEED_THR: cfg_prdata = 32'(cfg_r.seed_thr);
      snxn_pkg::REG_TIME_MIN: cfg_prdata = 32'(unsigned'(cfg_r.time_min));
      snxn_pkg::REG_TIME_MAX: cfg_prdata = 32'(unsigned'(cfg_r.time_max));
      snxn_pkg::REG_TIME_CUT: cfg_prdata = 32'(cfg_r.time_cut);
      snxn_pkg::REG_ROW_WIN:  cfg_prdata = 32'(cfg_r.row_win);
      snxn_pkg::REG_COL_WIN:  cfg_prdata = 32'(cfg_r.col_win);
      snxn_pkg::REG_GRADIENT: cfg_prdata = 32'(cfg_r.gradient);
      default:                cfg_prdata = '0;
    endcase
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_cell_id    = o_id_r;
  assign out_ch.cluster_index  = o_cidx_r;
  assign out_ch.cell_energy    = o_energy_r;
  assign out_ch.is_seed        = o_seed_r;
  assign out_ch.end_of_cluster = o_eoc_r;
  assign out_ch.end_of_event   = o_eoe_r;
  assign out_ch.empty_event    = o_empty_r;
  assign out_ch.overflow       = o_ovf_r;

  `SNXN_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_CELLS))
  `SNXN_ASSERT_NOW(a_pend_in_member, in_member, pend_v_r)
  `SNXN_ASSERT_NEXT(a_event_clear, ev_done, (cnt_r == '0) && !pend_v_r && out_v_r)

endmodule

// ===== sim/tb_seeded_nxn_cluster_finder_unit.sv =====
// Testbench for the seeded NxN cluster finder: directed rows, then random events.
// Results are checked against a local predictor of the clustering.
// Depends on snxn_pkg, snxn_ifs and the seeded_nxn_cluster_finder_unit RTL.
module tb_seeded_nxn_cluster_finder_unit;

  localparam int CELL_CAP     = 64;
  localparam int PAIR_COLS    = 48;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [14:0] cell_id;
    logic [5:0]  cluster_index;
    logic [15:0] cell_energy;
    logic        is_seed;
    logic        end_of_cluster;
    logic        end_of_event;
    logic        empty_event;
    logic        overflow;
  } cluster_item_t;

  typedef struct {
    snxn_pkg::entry_t cell_in;
    bit               last;
    bit               typed;
    cluster_item_t    item;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [snxn_pkg::ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  snxn_in_if  in_ch();
  snxn_out_if out_ch();

  seeded_nxn_cluster_finder_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  snxn_pkg::cfg_t   model_cfg;
  snxn_pkg::entry_t stored_cells [CELL_CAP];
  bit               cell_live [CELL_CAP];
  int               stored_cnt;
  logic [5:0]       cluster_cnt;
  bit               cells_dropped;
  cluster_item_t    cluster_expect [$];

  int   errors;
  int   items_checked;
  int   events_sent;
  int   cycles;
  int   burst_left;
  bit   long_hold_req;
  int   hold_left;
  int   pattern_mode;
  int   pattern_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic bit member_joins(int s, int m);
    int sms, smm, rs, rm, cs, cm, dr, dc;
    sms = stored_cells[s].sm;  smm = stored_cells[m].sm;
    rs = stored_cells[s].row;  rm = stored_cells[m].row;
    cs = stored_cells[s].col;  cm = stored_cells[m].col;
    if (model_cfg.gradient && stored_cells[m].energy > stored_cells[s].energy) return 1'b0;
    if (sms != smm) begin
      if ((sms >> 1) != (smm >> 1)) return 1'b0;
      if (sms & 1) cs += PAIR_COLS;
      else cm += PAIR_COLS;
    end
    dr = rs - rm; if (dr < 0) dr = -dr;
    dc = cs - cm; if (dc < 0) dc = -dc;
    return dc <= int'(model_cfg.col_win) && dr <= int'(model_cfg.row_win);
  endfunction

  function automatic cluster_item_t emitted_cell(int i, bit seed);
    cluster_item_t r;
    r = '0;
    r.cell_id = stored_cells[i].cell_id;
    r.cluster_index = cluster_cnt;
    r.cell_energy = stored_cells[i].energy;
    r.is_seed = seed;
    r.overflow = cells_dropped;
    return r;
  endfunction

  function automatic int absorb_cell(snxn_pkg::entry_t c, bit last);
    cluster_item_t batch [$];
    cluster_item_t r;
    int seed, best, dt;
    if (c.energy > model_cfg.min_cut) begin
      if (stored_cnt < CELL_CAP) begin
        stored_cells[stored_cnt] = c;
        cell_live[stored_cnt] = 1'b1;
        stored_cnt++;
      end else begin
        cells_dropped = 1'b1;
      end
    end
    if (!last) return 0;
    forever begin
      seed = -1;
      best = -1;
      for (int i = 0; i < stored_cnt; i++) begin
        if (cell_live[i] && stored_cells[i].energy > model_cfg.seed_thr &&
            $signed(stored_cells[i].hit_time) < $signed(model_cfg.time_max) &&
            $signed(stored_cells[i].hit_time) > $signed(model_cfg.time_min) &&
            int'(stored_cells[i].energy) > best) begin
          best = stored_cells[i].energy;
          seed = i;
        end
      end
      if (seed < 0 || batch.size() >= CELL_CAP) break;
      batch.push_back(emitted_cell(seed, 1'b1));
      for (int i = 0; i < stored_cnt; i++) begin
        if (!cell_live[i] || i == seed || stored_cells[i].energy == 0) continue;
        dt = int'($signed(stored_cells[seed].hit_time)) - int'($signed(stored_cells[i].hit_time));
        if (dt < 0) dt = -dt;
        if (dt > int'(model_cfg.time_cut)) continue;
        if (member_joins(seed, i) && batch.size() < CELL_CAP) begin
          batch.push_back(emitted_cell(i, 1'b0));
          cell_live[i] = 1'b0;
        end
      end
      cell_live[seed] = 1'b0;
      batch[batch.size()-1].end_of_cluster = 1'b1;
      cluster_cnt++;
    end
    if (batch.size() == 0) begin
      r = '0;
      r.empty_event = 1'b1;
      r.overflow = cells_dropped;
      batch.push_back(r);
    end
    batch[batch.size()-1].end_of_event = 1'b1;
    foreach (batch[i]) cluster_expect.push_back(batch[i]);
    for (int i = 0; i < CELL_CAP; i++) cell_live[i] = 1'b0;
    stored_cnt = 0;
    cluster_cnt = '0;
    cells_dropped = 1'b0;
    return batch.size();
  endfunction

  function automatic snxn_pkg::entry_t mk_cell(int id, int sm, int row, int col, int en, int t);
    snxn_pkg::entry_t c;
    c.cell_id = id[14:0];
    c.sm = sm[4:0];
    c.row = row[4:0];
    c.col = col[5:0];
    c.energy = en[15:0];
    c.hit_time = t[15:0];
    return c;
  endfunction

  function automatic stim_row_t mk_row(snxn_pkg::entry_t c, bit last, bit typed = 1'b0,
                                       cluster_item_t item = '0);
    stim_row_t r;
    r.cell_in = c;
    r.last = last;
    r.typed = typed;
    r.item = item;
    return r;
  endfunction

  task automatic write_reg(snxn_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      snxn_pkg::REG_MIN_CUT:  model_cfg.min_cut = v[15:0];
      snxn_pkg::REG_SEED_THR: model_cfg.seed_thr = v[15:0];
      snxn_pkg::REG_TIME_MIN: model_cfg.time_min = v[15:0];
      snxn_pkg::REG_TIME_MAX: model_cfg.time_max = v[15:0];
      snxn_pkg::REG_TIME_CUT: model_cfg.time_cut = v[15:0];
      snxn_pkg::REG_ROW_WIN:  model_cfg.row_win = v[4:0];
      snxn_pkg::REG_COL_WIN:  model_cfg.col_win = v[6:0];
      snxn_pkg::REG_GRADIENT: model_cfg.gradient = v[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(int mc, int st, int tmin, int tmax, int tc, int rw, int cw, int g);
    write_reg(snxn_pkg::REG_MIN_CUT, mc);
    write_reg(snxn_pkg::REG_SEED_THR, st);
    write_reg(snxn_pkg::REG_TIME_MIN, tmin);
    write_reg(snxn_pkg::REG_TIME_MAX, tmax);
    write_reg(snxn_pkg::REG_TIME_CUT, tc);
    write_reg(snxn_pkg::REG_ROW_WIN, rw);
    write_reg(snxn_pkg::REG_COL_WIN, cw);
    write_reg(snxn_pkg::REG_GRADIENT, g);
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (cluster_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_cell(snxn_pkg::entry_t c, bit last, output int n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.cell_id = c.cell_id;
    in_ch.supermodule = c.sm;
    in_ch.row = c.row;
    in_ch.col = c.col;
    in_ch.energy = c.energy;
    in_ch.hit_time = c.hit_time;
    in_ch.last_cell = last;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n = absorb_cell(c, last);
    if (last) events_sent++;
    @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    pattern_left = 0;
    pattern_mode = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (pattern_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cluster_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cell_id = out_ch.out_cell_id;
      got.cluster_index = out_ch.cluster_index;
      got.cell_energy = out_ch.cell_energy;
      got.is_seed = out_ch.is_seed;
      got.end_of_cluster = out_ch.end_of_cluster;
      got.end_of_event = out_ch.end_of_event;
      got.empty_event = out_ch.empty_event;
      got.overflow = out_ch.overflow;
      if (cluster_expect.size() == 0) begin
        $display("%0t: unexpected item %p", $time, got);
        errors++;
      end else begin
        want = cluster_expect.pop_front();
        items_checked++;
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t        rows [$];
    cluster_item_t    e;
    snxn_pkg::entry_t c;
    int n, sent, ncells, mode, csm, crow, ccol, ct;
    errors = 0;
    items_checked = 0;
    events_sent = 0;
    burst_left = 0;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cell_id = '0;
    in_ch.supermodule = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.energy = '0;
    in_ch.hit_time = '0;
    in_ch.last_cell = 1'b0;
    model_cfg = '{min_cut: 16'd0, seed_thr: 16'd0, time_min: 16'sh8000,
                  time_max: 16'sh7fff, time_cut: 16'hffff, row_win: 5'd1,
                  col_win: 7'd1, gradient: 1'b0};
    for (int i = 0; i < CELL_CAP; i++) cell_live[i] = 1'b0;
    stored_cnt = 0;
    cluster_cnt = '0;
    cells_dropped = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    e = '0; e.empty_event = 1'b1; e.end_of_event = 1'b1;
    rows.push_back(mk_row(mk_cell(32767, 0, 0, 0, 0, 0), 1'b1, 1'b1, e));
    rows.push_back(mk_row(mk_cell(5, 0, 0, 0, 65535, 0), 1'b1, 1'b1,
                          '{15'd5, 6'd0, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}));
    rows.push_back(mk_row(mk_cell(1, 0, 0, 0, 10, -32768), 1'b1, 1'b1, e));
    rows.push_back(mk_row(mk_cell(2, 0, 0, 0, 10, 32767), 1'b1, 1'b1, e));
    rows.push_back(mk_row(mk_cell(10, 0, 5, 47, 100, 0), 1'b0));
    rows.push_back(mk_row(mk_cell(11, 1, 5, 0, 50, 1), 1'b0));
    rows.push_back(mk_row(mk_cell(12, 2, 5, 0, 40, 0), 1'b0));
    rows.push_back(mk_row(mk_cell(13, 0, 6, 46, 30, -1), 1'b1));
    rows.push_back(mk_row(mk_cell(20, 3, 0, 0, 200, 0), 1'b0));
    rows.push_back(mk_row(mk_cell(21, 3, 20, 40, 200, 5), 1'b1));
    rows.push_back(mk_row(mk_cell(32767, 31, 31, 63, 1, -1), 1'b0));
    rows.push_back(mk_row(mk_cell(0, 30, 31, 63, 65535, 100), 1'b1));
    foreach (rows[i]) begin
      offer_cell(rows[i].cell_in, rows[i].last, n);
      if (rows[i].typed && n == 1) begin
        void'(cluster_expect.pop_back());
        cluster_expect.push_back(rows[i].item);
      end
    end
    wait_drain();

    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_cfg(0, 0, -32768, 32767, 0, 0, 0, 1);
        1: apply_cfg(0, 0, -32768, 32767, 65535, 23, 95, 0);
        2: apply_cfg(65535, 0, -32768, 32767, 65535, 1, 1, 0);
        3: apply_cfg(0, 65535, -32768, 32767, 65535, 1, 1, 0);
        default: apply_cfg($urandom_range(0, 60), $urandom_range(0, 800),
                           -int'($urandom_range(0, 300)), $urandom_range(0, 300),
                           $urandom_range(0, 60), $urandom_range(0, 4),
                           $urandom_range(0, 6), $urandom_range(0, 1));
      endcase
      while (sent < (phase + 1) * RANDOM_ITEMS / 8) begin
        if (phase == 1 || phase == 4 || phase == 6) ncells = 64 + $urandom_range(0, 6);
        else ncells = $urandom_range(1, 10);
        if (phase == 4) long_hold_req = 1'b1;
        csm = $urandom_range(0, 19);
        crow = $urandom_range(0, 23);
        ccol = $urandom_range(0, 47);
        ct = $urandom_range(0, 400) - 200;
        for (int k = 0; k < ncells; k++) begin
          mode = $urandom_range(0, 9);
          if (mode == 0) begin
            c = mk_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          end else begin
            c = mk_cell($urandom, ($urandom_range(0, 3) == 0) ? (csm ^ 1) : csm,
                        (crow + $urandom_range(0, 4)) % 24, (ccol + $urandom_range(0, 4)) % 48,
                        ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 65535 : 0)
                                                    : $urandom_range(1, 3000),
                        ($urandom_range(0, 9) == 0) ? $urandom
                                                    : ct + $urandom_range(0, 40) - 20);
          end
          offer_cell(c, k == ncells - 1, n);
          sent++;
        end
      end
      wait_drain();
    end

    $display("%0d events, %0d result items checked over 8 register settings", events_sent,
             items_checked);
    $display("including empty, overflowing and paired-module events");
    if (errors == 0 && cluster_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
